### rtl/hbp_pkg.sv
// shared constants, op codes and item types for the huffman bit packer
// used by every rtl file of the block
`default_nettype none
package hbp_pkg;

  localparam int SYMBOLS       = 256;
  localparam int MAX_CODE_BITS = 8;
  localparam int SYM_W         = 8;
  localparam int IDX_W         = $clog2(SYMBOLS);
  localparam int CODE_W        = 8;
  localparam int LEN_W         = 4;
  localparam int ENTRY_W       = LEN_W + CODE_W;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int FILL_W        = 3;
  localparam int WIN_W         = 2 * CODE_W;
  localparam int SHIFT_W       = $clog2(WIN_W + 1);

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_ENCODE = 2'd1;
  localparam logic [1:0] OP_FLUSH  = 2'd2;

  typedef struct packed {
    logic              is_flush;
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
  } hbp_item_t;

  typedef struct packed {
    logic              valid;
    logic              full;
    logic [QCNT_W-1:0] count;
  } hbp_qstat_t;

endpackage
`default_nettype wire

### rtl/hbp_front.sv
// front end: takes input items, keeps the code table and looks up codes
// depends on hbp_pkg; feeds hbp_queue
`default_nettype none
module hbp_front import hbp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        in_op,
  input  wire logic [SYM_W-1:0]  in_symbol,
  input  wire logic [CODE_W-1:0] in_entry_code,
  input  wire logic [LEN_W-1:0]  in_entry_length,
  input  wire hbp_qstat_t        q_stat,
  output logic                   q_push,
  output hbp_item_t              q_item
);

  logic [ENTRY_W-1:0] table_mem [SYMBOLS];
  logic [ENTRY_W-1:0] rd_data_r;
  logic               s1_valid_r, s1_valid_nxt;
  logic               s1_flush_r;
  logic               accept, sym_ok, do_load, do_encode;
  logic [LEN_W-1:0]   len_sat;
  logic [CODE_W-1:0]  code_masked;

  assign accept    = in_valid && in_ready;
  assign sym_ok    = (32'(in_symbol) < SYMBOLS);
  assign do_load   = accept && (in_op == OP_LOAD) && sym_ok;
  assign do_encode = accept && (in_op == OP_ENCODE) && sym_ok;
  assign q_push    = s1_valid_r && !q_stat.full;
  assign in_ready  = !s1_valid_r || !q_stat.full;

  assign len_sat = (32'(in_entry_length) > MAX_CODE_BITS) ? LEN_W'(MAX_CODE_BITS)
                                                          : in_entry_length;
  assign code_masked = in_entry_code & ~({CODE_W{1'b1}} << len_sat);

  assign q_item.is_flush = s1_flush_r;
  assign q_item.len      = rd_data_r[ENTRY_W-1:CODE_W];
  assign q_item.code     = rd_data_r[CODE_W-1:0];

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (q_push) begin
      s1_valid_nxt = 1'b0;
    end
    if (do_encode || (accept && in_op == OP_FLUSH)) begin
      s1_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_flush_r <= (in_op == OP_FLUSH);
    end
  end

  // code table
  always_ff @(posedge clk) begin
    if (do_load) begin
      table_mem[in_symbol[IDX_W-1:0]] <= {len_sat, code_masked};
    end
    if (do_encode) begin
      rd_data_r <= table_mem[in_symbol[IDX_W-1:0]];
    end
  end

endmodule
`default_nettype wire

### rtl/hbp_queue.sv
// short item queue between front and back ends
// depends on hbp_pkg
`default_nettype none
module hbp_queue import hbp_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire hbp_item_t push_item,
  input  wire logic      pop,
  output hbp_item_t      head_item,
  output hbp_qstat_t     stat
);

  hbp_item_t         slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign head_item  = slot_r[rd_ptr_r];
  assign stat.valid = (count_r != '0);
  assign stat.full  = (32'(count_r) == QUEUE_DEPTH);
  assign stat.count = count_r;

  always_comb begin
    count_nxt = count_r;
    case ({push, pop})
      2'b10:   count_nxt = count_r + QCNT_W'(1);
      2'b01:   count_nxt = count_r - QCNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (32'(wr_ptr_r) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (32'(rd_ptr_r) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

### rtl/hbp_back.sv
// back end: packs codes into the accumulator and registers output bytes
// depends on hbp_pkg; drains hbp_queue
`default_nettype none
module hbp_back import hbp_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire hbp_qstat_t   q_stat,
  input  wire hbp_item_t    q_item,
  output logic              q_pop,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [CODE_W-1:0] out_packed_byte,
  output logic              out_last
);

  logic [CODE_W-1:0]  acc_r, acc_nxt;
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [CODE_W-1:0]  out_byte_r;
  logic               out_last_r;
  logic               emit;
  logic [CODE_W-1:0]  emit_byte;
  logic               emit_last;
  logic [LEN_W:0]     total;
  logic [SHIFT_W-1:0] shamt;
  logic [WIN_W-1:0]   word;

  assign q_pop           = q_stat.valid && (!out_valid_r || out_ready);
  assign out_valid       = out_valid_r;
  assign out_packed_byte = out_byte_r;
  assign out_last        = out_last_r;

  assign total = (LEN_W+1)'(fill_r) + (LEN_W+1)'(q_item.len);
  assign shamt = SHIFT_W'(WIN_W) - SHIFT_W'(total);
  // held bits on top, new code right after them
  assign word  = {acc_r, {CODE_W{1'b0}}} | ({{CODE_W{1'b0}}, q_item.code} << shamt);

  always_comb begin
    acc_nxt   = acc_r;
    fill_nxt  = fill_r;
    emit      = 1'b0;
    emit_byte = word[WIN_W-1:CODE_W];
    emit_last = 1'b0;
    if (q_pop) begin
      if (q_item.is_flush) begin
        if (fill_r != '0) begin
          emit      = 1'b1;
          emit_byte = acc_r;
          emit_last = 1'b1;
          acc_nxt   = '0;
          fill_nxt  = '0;
        end
      end else if (32'(total) >= CODE_W) begin
        emit     = 1'b1;
        acc_nxt  = word[CODE_W-1:0];
        fill_nxt = FILL_W'(total - (LEN_W+1)'(CODE_W));
      end else begin
        acc_nxt  = word[WIN_W-1:CODE_W];
        fill_nxt = FILL_W'(total);
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r <= emit_byte;
      out_last_r <= emit_last;
    end
  end

endmodule
`default_nettype wire

### rtl/huffman_bit_packer.sv
// huffman bit packer top level: front end, item queue, back end
// encode and flush items go through the front stage, queue and output registers
// throughput: one item per cycle while out_ready holds; a stalled output fills the
// queue and front stage, then holds in_ready low
// reset clears the queue, accumulator and output valid; code table is not cleared
`default_nettype none
module huffman_bit_packer import hbp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        in_op,
  input  wire logic [SYM_W-1:0]  in_symbol,
  input  wire logic [CODE_W-1:0] in_entry_code,
  input  wire logic [LEN_W-1:0]  in_entry_length,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [CODE_W-1:0]      out_packed_byte,
  output logic                   out_last
);

  hbp_qstat_t q_stat;
  hbp_item_t  push_item, head_item;
  logic       q_push, q_pop;

  hbp_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_symbol       (in_symbol),
    .in_entry_code   (in_entry_code),
    .in_entry_length (in_entry_length),
    .q_stat          (q_stat),
    .q_push          (q_push),
    .q_item          (push_item)
  );

  hbp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .head_item (head_item),
    .stat      (q_stat)
  );

  hbp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_stat          (q_stat),
    .q_item          (head_item),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_packed_byte (out_packed_byte),
    .out_last        (out_last)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_stat.full))
    else $error("item pushed into full queue");

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(q_stat.count) <= QUEUE_DEPTH)
    else $error("queue count out of range");

  a_result_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid ##1 out_valid) |-> $past(q_pop))
    else $error("result shown without an item taken from the queue");

endmodule
`default_nettype wire
